// ===== rtl/paat_pkg.sv =====
// shared types and constants of the peer address aging table
package paat_pkg;

  localparam int ADDR_W = 48;
  localparam int TIME_W = 32;
  localparam int TMO_W = 12;
  localparam int LIMIT_W = 22;
  localparam logic [9:0] MS_PER_SEC = 10'd1000;

  localparam logic FUNC_SIGHTING = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  localparam logic [2:0] REG_TIMEOUT = 3'd0;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 12'd10;

  // token that walks down the cell row
  typedef struct packed {
    logic              valid;
    logic              sighting;
    logic              sweep;
    logic              hit;
    logic              free_found;
    logic [ADDR_W-1:0] addr;
  } tok_t;

endpackage

// ===== rtl/peer_address_aging_table.sv =====
// peer address aging table: controller, config register and row of entry cells
//
//  channel  dir  handshake                  payload
//  s_*      in   s_tvalid / s_tready        s_tdata: mac_address, now_ms; s_tuser: func
//  m_*      out  m_tvalid / m_tready        m_tdata: active_count, newly_added,
//                                           dropped_full, sweep_done
//  apb      in   psel, penable, pwrite      timeout_seconds at byte address 0
//
// for each item the accepting edge launches a token into tok0, the token walks the cell
// row one entry per cycle, the result is applied to the count and registered in res,
// and it then moves into the output register; a stalled output holds it back in HOLD.
// reset empties the table, zeroes the peer count and period start, timeout is 10.
// a new item is accepted once the previous result has reached the output register.
module peer_address_aging_table import paat_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // [47:0] mac_address, [79:48] now_ms
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [4:0] active_count, [5] newly_added,
                                 // [6] dropped_full, [7] sweep_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {IDLE, WALK, HOLD} state_t;

  state_t             state;
  logic [TMO_W-1:0]   timeout;
  logic [TIME_W-1:0]  period_start;
  logic [TIME_W-1:0]  now_r;
  logic [CW-1:0]      peer_count;
  logic [7:0]         res;
  tok_t               tok0;

  tok_t               tok_c [ENTRIES+1];
  logic [IW-1:0]      idx_c [ENTRIES+1];
  logic [CW-1:0]      cnt_c [ENTRIES+1];

  logic               s_xfer;
  logic               cfg_wr;
  logic [LIMIT_W-1:0] limit;
  logic [TIME_W-1:0]  elapsed;
  logic               expired;
  tok_t               tok_last;
  logic               last_arrive;
  logic               ins_en;
  logic [CW-1:0]      count_next;
  logic [31:0]        count_wide;
  logic               added;
  logic               full;
  logic               swept;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_TIMEOUT);
  assign prdata = (paddr == REG_TIMEOUT) ? {20'd0, timeout} : 32'd0;

  assign s_tready = (state == IDLE);
  assign s_xfer = s_tvalid && s_tready;

  assign limit = timeout * MS_PER_SEC;
  assign elapsed = s_tdata[79:48] - period_start;
  assign expired = elapsed >= TIME_W'(limit);

  assign tok_c[0] = tok0;
  assign idx_c[0] = '0;
  assign cnt_c[0] = '0;
  assign tok_last = tok_c[ENTRIES];
  assign last_arrive = (state == WALK) && tok_last.valid;

  assign ins_en = last_arrive && tok_last.sighting && !tok_last.hit && tok_last.free_found;

  always_comb begin
    count_next = peer_count;
    added = 1'b0;
    full = 1'b0;
    swept = 1'b0;
    if (tok_last.sighting) begin
      if (!tok_last.hit) begin
        if (tok_last.free_found) begin
          added = 1'b1;
          count_next = peer_count + CW'(1);
        end else begin
          full = 1'b1;
        end
      end
    end else if (tok_last.sweep) begin
      swept = 1'b1;
      count_next = cnt_c[ENTRIES];
    end
  end

  assign count_wide = 32'(count_next);

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    paat_cell #(
      .IDX (g),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok_c[g]),
      .idx_in   (idx_c[g]),
      .cnt_in   (cnt_c[g]),
      .tok_out  (tok_c[g+1]),
      .idx_out  (idx_c[g+1]),
      .cnt_out  (cnt_c[g+1]),
      .ins_en   (ins_en),
      .ins_idx  (idx_c[ENTRIES]),
      .ins_addr (tok_last.addr)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      timeout <= TIMEOUT_RESET;
      period_start <= '0;
      peer_count <= '0;
      tok0 <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        timeout <= pwdata[TMO_W-1:0];
      end
      tok0.valid <= s_xfer;
      m_tvalid <= (state == HOLD) || (m_tvalid && !m_tready);
      unique case (state)
        IDLE: begin
          if (s_xfer) begin
            tok0.sighting <= (s_tuser == FUNC_SIGHTING);
            tok0.sweep <= (s_tuser == FUNC_CHECK) && expired;
            tok0.hit <= 1'b0;
            tok0.free_found <= 1'b0;
            tok0.addr <= s_tdata[47:0];
            now_r <= s_tdata[79:48];
            state <= WALK;
          end
        end
        WALK: begin
          if (last_arrive) begin
            peer_count <= count_next;
            if (swept) begin
              period_start <= now_r;
            end
            res <= {swept, full, added, count_wide[4:0]};
            state <= HOLD;
          end
        end
        HOLD: begin
          // output register frees or is already empty
          if (!m_tvalid || m_tready) begin
            m_tdata <= res;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/paat_cell.sv =====
// one table entry of the cell row: address, valid and seen mark
module paat_cell import paat_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  tok_t              tok_in,
  input  logic [IW-1:0]     idx_in,
  input  logic [CW-1:0]     cnt_in,
  output tok_t              tok_out,
  output logic [IW-1:0]     idx_out,
  output logic [CW-1:0]     cnt_out,
  input  logic              ins_en,
  input  logic [IW-1:0]     ins_idx,
  input  logic [ADDR_W-1:0] ins_addr
);

  logic              valid;
  logic              seen;
  logic [ADDR_W-1:0] addr;
  logic              valid_next;
  logic              seen_next;
  logic              ins_here;
  tok_t              tok_next;
  logic [IW-1:0]     idx_next;
  logic [CW-1:0]     cnt_next;

  assign ins_here = ins_en && (ins_idx == IW'(IDX));

  always_comb begin
    tok_next = tok_in;
    idx_next = idx_in;
    cnt_next = cnt_in;
    valid_next = valid;
    seen_next = seen;
    if (tok_in.valid) begin
      if (tok_in.sighting) begin
        if (valid && (addr == tok_in.addr)) begin
          seen_next = 1'b1;
          tok_next.hit = 1'b1;
        end else if (!valid && !tok_in.free_found) begin
          // lowest free entry claims the insert slot
          tok_next.free_found = 1'b1;
          idx_next = IW'(IDX);
        end
      end else if (tok_in.sweep) begin
        valid_next = valid & seen;
        seen_next = 1'b0;
        cnt_next = cnt_in + CW'(valid & seen);
      end
    end
    if (ins_here) begin
      valid_next = 1'b1;
      seen_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      seen <= 1'b0;
      tok_out <= '0;
    end else begin
      valid <= valid_next;
      seen <= seen_next;
      tok_out <= tok_next;
    end
    idx_out <= idx_next;
    cnt_out <= cnt_next;
    if (ins_here) begin
      addr <= ins_addr;
    end
  end

endmodule
